>>> src/sobel_edge_magnitude_top_macros.svh
// assertion macros for the sobel edge magnitude block
`ifndef SOBEL_EDGE_MAGNITUDE_TOP_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define SEM_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SEM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/sem_pkg.sv
// shared constants and types for the sobel edge magnitude block
`default_nettype none

package sem_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int PIX_W     = 8;
	localparam int LINE_W    = 2 * PIX_W;
	localparam int GRAD_W    = PIX_W + 3;

	localparam int WIDTH_W   = 11;
	localparam int HEIGHT_W  = 12;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 1;
	localparam int WCMP_W    = (WIDTH_W > COL_W + 1) ? WIDTH_W : COL_W + 1;

	localparam int WIDTH_MIN    = 3;
	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_MIN   = 3;
	localparam int HEIGHT_RESET = 480;

	localparam int EDGE_MAX = 255;

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH  = 1'b0,
		CFG_IMAGE_HEIGHT = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic             end_of_frame;
		logic [PIX_W-1:0] edge_value;
	} sem_word_t;

endpackage

`default_nettype wire

>>> src/sem_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module sem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> src/sem_fifo.sv
// output word queue for the sobel edge magnitude block
`default_nettype none

module sem_fifo import sem_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire sem_word_t          push_word,
	input  wire logic               pop,
	output logic                    out_valid,
	output sem_word_t               out_word,
	output logic      [FIFO_CW-1:0] level
);

	sem_word_t          mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + FIFO_CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FIFO_CW'(1);
			end
		end
	end

	assign out_valid = (count_q != '0);
	assign out_word  = mem_q[rd_ptr_q];
	assign level     = count_q;

endmodule

`default_nettype wire

>>> src/sobel_edge_magnitude_top.sv
// sobel edge magnitude: top level with line memory, window and gradient pipeline
// an accepted pixel moves through the s1, s2 and s3 registers into the output queue
// throughput: one pixel per cycle unless stalled; line memory read-modify-write per pixel
// input stalls only when the 8-word output queue plus words in flight would overflow
// reset: async, clears counters, pipeline valids and queue; width 640, height 480
// the line memory is not cleared and needs no clearing pass
`default_nettype none

module sobel_edge_magnitude_top import sem_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [PIX_W-1:0]     s_tdata,   // pixel
	input  wire logic                 s_tuser,   // frame_start
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [PIX_W-1:0]     m_tdata,   // edge_value
	output logic                      m_tlast,   // end_of_frame
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	typedef struct packed {
		logic valid;
		logic emit;
		logic inner;
		logic eof;
	} sem_ctrl_t;

	logic [WIDTH_W-1:0]  image_width_q;
	logic [HEIGHT_W-1:0] image_height_q;
	logic [COL_W-1:0]    col_q;
	logic [HEIGHT_W-1:0] row_q;

	logic [WCMP_W-1:0]   width_ext;
	logic [WCMP_W-1:0]   col_last;
	logic [HEIGHT_W-1:0] row_last;
	logic                accept;
	logic [COL_W-1:0]    col_cur;
	logic [HEIGHT_W-1:0] row_cur;
	logic                last_col;
	logic                last_row;
	sem_ctrl_t           ctrl_cur;

	sem_ctrl_t           ctrl_s1;
	logic [PIX_W-1:0]    px_s1;
	logic [COL_W-1:0]    col_s1;
	logic                fwd_hit_s1;
	logic [LINE_W-1:0]   fwd_data_s1;
	logic [LINE_W-1:0]   ram_rdata;
	logic [LINE_W-1:0]   line_rd;
	logic [PIX_W-1:0]    line_top;
	logic [PIX_W-1:0]    line_mid;
	logic                wr_en;
	logic [LINE_W-1:0]   wr_data;

	logic [PIX_W-1:0]    win_q [3][3];
	sem_ctrl_t           ctrl_s2;
	logic [PIX_W+1:0]    sum_left;
	logic [PIX_W+1:0]    sum_right;
	logic [PIX_W+1:0]    sum_top;
	logic [PIX_W+1:0]    sum_bottom;
	logic signed [GRAD_W-1:0] gx;
	logic signed [GRAD_W-1:0] gy;

	sem_ctrl_t           ctrl_s3;
	logic signed [GRAD_W-1:0] gx_s3;
	logic signed [GRAD_W-1:0] gy_s3;
	logic [GRAD_W-1:0]   mag_x;
	logic [GRAD_W-1:0]   mag_y;
	logic [GRAD_W:0]     mag_sum;
	logic [PIX_W-1:0]    mag_clamped;
	logic                push;
	sem_word_t           push_word;
	sem_word_t           out_word;
	logic [FIFO_CW-1:0]  fifo_level;
	logic [FIFO_CW-1:0]  inflight;
	logic [FIFO_CW:0]    occupancy;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_W'(WIDTH_RESET);
			image_height_q <= HEIGHT_W'(HEIGHT_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data[WIDTH_W-1:0];
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		width_ext = WCMP_W'(image_width_q);
		if (width_ext < WCMP_W'(WIDTH_MIN)) begin
			col_last = WCMP_W'(WIDTH_MIN - 1);
		end else if (width_ext > WCMP_W'(MAX_WIDTH)) begin
			col_last = WCMP_W'(MAX_WIDTH - 1);
		end else begin
			col_last = width_ext - WCMP_W'(1);
		end
		if (image_height_q < HEIGHT_W'(HEIGHT_MIN)) begin
			row_last = HEIGHT_W'(HEIGHT_MIN - 1);
		end else begin
			row_last = image_height_q - HEIGHT_W'(1);
		end
	end

	// position of the accepted pixel
	assign accept   = s_tvalid & s_tready;
	assign col_cur  = s_tuser ? '0 : col_q;
	assign row_cur  = s_tuser ? '0 : row_q;
	assign last_col = (WCMP_W'(col_cur) >= col_last);
	assign last_row = (row_cur >= row_last);

	always_comb begin
		ctrl_cur.valid = accept;
		ctrl_cur.emit  = (row_cur >= HEIGHT_W'(2))
			|| ((row_cur == HEIGHT_W'(1)) && (col_cur >= COL_W'(1)));
		ctrl_cur.inner = (row_cur >= HEIGHT_W'(2)) && (col_cur >= COL_W'(2));
		ctrl_cur.eof   = last_col && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_cur + HEIGHT_W'(1);
			end else begin
				col_q <= col_cur + COL_W'(1);
				row_q <= row_cur;
			end
		end
	end

	// line memory: entry holds {two rows up, one row up}
	sem_ram #(
		.WIDTH (LINE_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (col_s1),
		.wdata (wr_data),
		.raddr (col_cur),
		.rdata (ram_rdata)
	);

	// read and write of the same column in one cycle
	assign line_rd  = fwd_hit_s1 ? fwd_data_s1 : ram_rdata;
	assign line_top = line_rd[LINE_W-1:PIX_W];
	assign line_mid = line_rd[PIX_W-1:0];
	assign wr_en    = ctrl_s1.valid;
	assign wr_data  = {line_mid, px_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
		end else begin
			ctrl_s1 <= ctrl_cur;
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
		end
	end

	always_ff @(posedge clk) begin
		px_s1       <= s_tdata;
		col_s1      <= col_cur;
		fwd_hit_s1  <= wr_en && (col_s1 == col_cur);
		fwd_data_s1 <= wr_data;
		gx_s3       <= gx;
		gy_s3       <= gy;
	end

	// 3x3 window, column 2 is newest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (ctrl_s1.valid) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= line_top;
			win_q[1][2] <= line_mid;
			win_q[2][2] <= px_s1;
		end
	end

	// gradients
	always_comb begin
		sum_left   = {2'b00, win_q[0][0]} + {1'b0, win_q[1][0], 1'b0} + {2'b00, win_q[2][0]};
		sum_right  = {2'b00, win_q[0][2]} + {1'b0, win_q[1][2], 1'b0} + {2'b00, win_q[2][2]};
		sum_top    = {2'b00, win_q[0][0]} + {1'b0, win_q[0][1], 1'b0} + {2'b00, win_q[0][2]};
		sum_bottom = {2'b00, win_q[2][0]} + {1'b0, win_q[2][1], 1'b0} + {2'b00, win_q[2][2]};
		gx = $signed({1'b0, sum_left}) - $signed({1'b0, sum_right});
		gy = $signed({1'b0, sum_top}) - $signed({1'b0, sum_bottom});
	end

	// magnitude and clamp
	always_comb begin
		mag_x   = gx_s3[GRAD_W-1] ? GRAD_W'(-gx_s3) : GRAD_W'(gx_s3);
		mag_y   = gy_s3[GRAD_W-1] ? GRAD_W'(-gy_s3) : GRAD_W'(gy_s3);
		mag_sum = {1'b0, mag_x} + {1'b0, mag_y};
		if (mag_sum > (GRAD_W+1)'(EDGE_MAX)) begin
			mag_clamped = PIX_W'(EDGE_MAX);
		end else begin
			mag_clamped = mag_sum[PIX_W-1:0];
		end
		push                   = ctrl_s3.valid && ctrl_s3.emit;
		push_word.edge_value   = ctrl_s3.inner ? mag_clamped : '0;
		push_word.end_of_frame = ctrl_s3.eof;
	end

	sem_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (m_tvalid && m_tready),
		.out_valid (m_tvalid),
		.out_word  (out_word),
		.level     (fifo_level)
	);

	assign m_tdata = out_word.edge_value;
	assign m_tlast = out_word.end_of_frame;

	// credit: reserve queue space for every word still in the pipeline
	assign inflight = FIFO_CW'(ctrl_s1.valid && ctrl_s1.emit)
		+ FIFO_CW'(ctrl_s2.valid && ctrl_s2.emit)
		+ FIFO_CW'(ctrl_s3.valid && ctrl_s3.emit);
	assign occupancy = {1'b0, fifo_level} + {1'b0, inflight};
	assign s_tready  = (occupancy < (FIFO_CW+1)'(FIFO_DEPTH));

endmodule

`default_nettype wire

>>> src/sem_checker.sv
// port-level checker for the sobel edge magnitude block, bound to the top level
`default_nettype none

`include "sobel_edge_magnitude_top_macros.svh"

module sem_checker import sem_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_tvalid,
	input wire logic             s_tready,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [PIX_W-1:0] m_tdata,   // edge_value
	input wire logic             m_tlast    // end_of_frame
);

	`SEM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output word changed while stalled")
	`SEM_ASSERT_SAME(a_stall_needs_backlog, !s_tready, m_tvalid, "input stalled with empty output")
	`SEM_ASSERT_SAME(a_first_word_latency, $rose(m_tvalid), $past(s_tvalid && s_tready, 4), "output word without matching input")

endmodule

bind sobel_edge_magnitude_top sem_checker u_sem_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tlast   (m_tlast)
);

`default_nettype wire

>>> bench/sobel_edge_magnitude_top_tb.sv
// self-checking testbench for the sobel edge magnitude block with its own edge predictor
`default_nettype none

module sobel_edge_magnitude_top_tb;
	import sem_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 10;
	localparam int STALL_AFTER  = 80;
	localparam int STALL_CYCLES = 200;
	localparam int RANDOM_ITEMS = 160;

	typedef enum {
		FILL_RANDOM, FILL_BINARY, FILL_ZERO, FILL_FULL,
		FILL_VERTICAL, FILL_HORIZONTAL, FILL_DIAGONAL
	} fill_t;

	typedef struct packed {
		logic             start;
		logic [PIX_W-1:0] px;
	} pixel_item_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [PIX_W-1:0]     s_tdata = '0;   // pixel
	logic                 s_tuser = 1'b0; // frame_start
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [PIX_W-1:0]     m_tdata;        // edge_value
	logic                 m_tlast;        // end_of_frame
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	sobel_edge_magnitude_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor state
	logic [WIDTH_W-1:0]  width_reg  = WIDTH_W'(WIDTH_RESET);
	logic [HEIGHT_W-1:0] height_reg = HEIGHT_W'(HEIGHT_RESET);
	logic [PIX_W-1:0]    upper_line [MAX_WIDTH];
	logic [PIX_W-1:0]    middle_line [MAX_WIDTH];
	logic [PIX_W-1:0]    win [9] = '{default: '0};
	int unsigned         col_pos = 0;
	int unsigned         row_pos = 0;

	pixel_item_t pixel_queue [$];
	sem_word_t   expected_words [$];
	int          pushed_count = 0;
	int          pixels_accepted = 0;
	int          results_seen = 0;
	int          errors = 0;
	int          cycle_count = 0;
	int          hold_left = 0;
	logic        hold_done = 1'b0;
	logic        steady_flow;

	assign steady_flow = cycle_count >= 1500 && cycle_count < 2500;

	initial begin
		forever #10 clk = ~clk;
	end

	task automatic sobel_predict(input logic [PIX_W-1:0] px, input logic start);
		int unsigned w, h, r, c;
		int p [9];
		int gx, gy, mag;
		logic [PIX_W-1:0] top, mid;
		logic last_col, last_row;
		sem_word_t word;
		w = (width_reg < WIDTH_MIN) ? WIDTH_MIN :
			(width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
		h = (height_reg < HEIGHT_MIN) ? HEIGHT_MIN : height_reg;
		if (start) begin
			col_pos = 0;
			row_pos = 0;
		end
		r = row_pos;
		c = col_pos;
		top = upper_line[c];
		mid = middle_line[c];
		upper_line[c] = mid;
		middle_line[c] = px;
		for (int k = 0; k < 3; k++) begin
			win[k*3]   = win[k*3+1];
			win[k*3+1] = win[k*3+2];
		end
		win[2] = top;
		win[5] = mid;
		win[8] = px;
		mag = 0;
		if (r >= 2 && c >= 2) begin
			for (int k = 0; k < 9; k++)
				p[k] = win[k];
			gx = p[0] + 2 * p[3] + p[6] - p[2] - 2 * p[5] - p[8];
			gy = p[0] + 2 * p[1] + p[2] - p[6] - 2 * p[7] - p[8];
			mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
			if (mag > EDGE_MAX)
				mag = EDGE_MAX;
		end
		last_col = c >= w - 1;
		last_row = r >= h - 1;
		if (last_col) begin
			col_pos = 0;
			row_pos = last_row ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
		if (r >= 2 || (r == 1 && c >= 1)) begin
			word.edge_value   = mag[PIX_W-1:0];
			word.end_of_frame = last_col && last_row;
			expected_words.push_back(word);
		end
	endtask

	// pixel driver
	always @(posedge clk or negedge arst_n) begin : pixel_driver
		pixel_item_t item;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				sobel_predict(s_tdata, s_tuser);
				pixels_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (pixel_queue.size() != 0 && (steady_flow || $urandom_range(99) >= 29)) begin
					item = pixel_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= item.px;
					s_tuser  <= item.start;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result ready, with one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && results_seen >= STALL_AFTER) begin
			m_tready  <= 1'b0;
			hold_left <= STALL_CYCLES;
			hold_done <= 1'b1;
		end else begin
			m_tready <= steady_flow || $urandom_range(99) >= 29;
		end
	end

	// result monitor
	always @(posedge clk) begin : result_monitor
		sem_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (expected_words.size() == 0) begin
				$display("%0t: word with nothing expected, actual edge_value %0d end_of_frame %0b",
					$time, m_tdata, m_tlast);
				errors++;
			end else begin
				want = expected_words.pop_front();
				if (m_tdata !== want.edge_value) begin
					$display("%0t: edge_value expected %0d, actual %0d",
						$time, want.edge_value, m_tdata);
					errors++;
				end
				if (m_tlast !== want.end_of_frame) begin
					$display("%0t: end_of_frame expected %0b, actual %0b",
						$time, want.end_of_frame, m_tlast);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic wait_idle();
		do
			@(posedge clk);
		while (pixels_accepted != pushed_count || expected_words.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		if (idx == CFG_IMAGE_WIDTH)
			width_reg = value[WIDTH_W-1:0];
		else
			height_reg = value[HEIGHT_W-1:0];
	endtask

	task automatic set_size(input logic [CFG_W-1:0] w_value, input logic [CFG_W-1:0] h_value);
		write_reg(CFG_IMAGE_WIDTH, w_value);
		write_reg(CFG_IMAGE_HEIGHT, h_value);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_frame(input int w, input int h, input int first, input int count,
		input fill_t fill, input logic start);
		pixel_item_t item;
		int r, c;
		for (int i = first; i < first + count; i++) begin
			r = i / w;
			c = i % w;
			case (fill)
				FILL_RANDOM:     item.px = PIX_W'($urandom_range(255));
				FILL_BINARY:     item.px = $urandom_range(1) ? 8'hFF : 8'h00;
				FILL_ZERO:       item.px = 8'h00;
				FILL_FULL:       item.px = 8'hFF;
				FILL_VERTICAL:   item.px = (c < w / 2) ? 8'hFF : 8'h00;
				FILL_HORIZONTAL: item.px = (r < h / 2) ? 8'hFF : 8'h00;
				default:         item.px = (c > r) ? 8'hFF : 8'h00;
			endcase
			item.start = start && i == first;
			pixel_queue.push_back(item);
		end
		pushed_count += count;
	endtask

	initial begin : stimulus
		int wv, hv, ew, eh, frames, count, random_pixels;
		logic broke, start;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset geometry, too few pixels for any result
		push_frame(640, 480, 0, 8, FILL_RANDOM, 1'b1);
		wait_idle();

		// out-of-range low values clamp to 3x3
		set_size(12'd0, 12'd1);
		push_frame(3, 3, 0, 9, FILL_ZERO, 1'b1);
		push_frame(3, 3, 0, 9, FILL_FULL, 1'b0);
		push_frame(3, 3, 0, 9, FILL_VERTICAL, 1'b0);
		push_frame(3, 3, 0, 9, FILL_HORIZONTAL, 1'b1);
		push_frame(3, 3, 0, 9, FILL_DIAGONAL, 1'b0);
		push_frame(3, 3, 0, 9, FILL_BINARY, 1'b0);
		push_frame(3, 3, 0, 5, FILL_RANDOM, 1'b1);
		push_frame(3, 3, 0, 9, FILL_RANDOM, 1'b1);
		wait_idle();

		// height shrinks mid-frame below the current row
		set_size(12'd5, 12'd8);
		push_frame(5, 8, 0, 20, FILL_DIAGONAL, 1'b1);
		wait_idle();
		write_reg(CFG_IMAGE_HEIGHT, 12'd3);
		@(posedge clk);
		cfg_we <= 1'b0;
		push_frame(5, 3, 0, 5, FILL_BINARY, 1'b0);
		push_frame(5, 3, 0, 15, FILL_RANDOM, 1'b0);
		push_frame(5, 3, 0, 15, FILL_VERTICAL, 1'b1);
		wait_idle();

		// all-ones width clamps to the widest line, wrap into the second row
		set_size(12'hFFF, 12'd3);
		push_frame(MAX_WIDTH, 3, 0, MAX_WIDTH + 4, FILL_RANDOM, 1'b1);
		wait_idle();

		// tallest frame, only its top rows
		set_size(12'd4, 12'hFFF);
		push_frame(4, 4095, 0, 40, FILL_BINARY, 1'b1);
		wait_idle();

		random_pixels = 0;
		while (random_pixels < RANDOM_ITEMS) begin
			wv = ($urandom_range(7) == 0) ? $urandom_range(2) :
				($urandom_range(15) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
			hv = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 8);
			ew = (wv < WIDTH_MIN) ? WIDTH_MIN : wv;
			eh = (hv < HEIGHT_MIN) ? HEIGHT_MIN : hv;
			set_size(CFG_W'(wv), CFG_W'(hv));
			frames = $urandom_range(1, 4);
			broke = 1'b0;
			for (int f = 0; f < frames; f++) begin
				start = f == 0 || broke || $urandom_range(1);
				if ($urandom_range(99) < 15) begin
					count = $urandom_range(1, ew * eh - 1);
					broke = 1'b1;
				end else begin
					count = ew * eh;
					broke = 1'b0;
				end
				push_frame(ew, eh, 0, count, fill_t'($urandom_range(6)), start);
				random_pixels += count;
			end
			wait_idle();
		end

		repeat (2 * DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_words.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
+incdir+src
src/sem_pkg.sv
src/sem_ram.sv
src/sem_fifo.sv
src/sobel_edge_magnitude_top.sv
src/sem_checker.sv
bench/sobel_edge_magnitude_top_tb.sv
